// ===== src/mbra_pkg.sv =====
// shared types, codes and helpers for the median batch response averager
package mbra_pkg;

    // batch store depth
    localparam int unsigned MaxBatch = 16;
    localparam int unsigned IdxW     = $clog2(MaxBatch);

    // divider runs one quotient bit per cycle
    localparam int unsigned DivSteps = 32;
    localparam int unsigned DivCntW  = $clog2(DivSteps);

    // register reset values
    localparam logic [4:0]  BATCH_SIZE_RST    = 5'd8;
    localparam logic [31:0] SYNC_INTERVAL_RST = 32'd1000000;

    // configuration register indexes
    typedef enum logic {
        REG_BATCH_SIZE    = 1'b0,
        REG_SYNC_INTERVAL = 1'b1
    } t_reg_idx;

    // input commands
    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_FINISH = 2'd1,
        CMD_SYNC   = 2'd2,
        CMD_FINAL  = 2'd3
    } t_cmd;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_DONE = 2'd2
    } t_state;

    // input item
    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] now_us;
        logic [31:0] ping_us;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [31:0] avg_latency_us;
        logic [31:0] report_count;
        logic        from_ping;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_req;
        logic ping_req;
    } t_dp_stat;

    // batch size clamped to 1..MaxBatch
    function automatic logic [4:0] eff_size(input logic [4:0] bs);
        logic [4:0] r;
        if (bs == 5'd0) begin
            r = 5'd1;
        end else if (bs > 5'(MaxBatch)) begin
            r = 5'(MaxBatch);
        end else begin
            r = bs;
        end
        return r;
    endfunction

endpackage

// ===== src/median_batch_response_averager.sv =====
// top level of the median batch response averager
//
// Start, finish and sync commands yield no result unless a sync reports. A
// ping fallback report is ready in the cycle after the item is taken; a mean
// of medians report waits for the serial restoring divider, which produces
// one quotient bit per cycle. The block takes one item at a time and takes
// no new item until the result has been taken. Batch latencies are kept as
// a sorted row of 16 cells updated by insertion, so the upper median is
// known as the batch fills. Configuration writes are taken at any time and
// should be made only while the block is idle.
module median_batch_response_averager (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mbra_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mbra_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    mbra_pkg::t_ctl_cmd ctl_cmd;
    mbra_pkg::t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    // control
    mbra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (ctl_cmd)
    );

    // datapath
    mbra_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (ctl_cmd),
        .o_stat      (dp_stat),
        .o_result    (o_out_data)
    );

endmodule

// ===== src/mbra_ctrl.sv =====
// controller state machine for the median batch response averager
module mbra_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  mbra_pkg::t_dp_stat  i_stat,
    output mbra_pkg::t_ctl_cmd  o_cmd
);

    mbra_pkg::t_state r_state, n_state;
    logic [mbra_pkg::DivCntW-1:0] r_cnt, n_cnt;
    logic div_last;

    assign div_last = (r_cnt == mbra_pkg::DivCntW'(mbra_pkg::DivSteps - 1));

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbra_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            mbra_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    if (i_stat.div_req) begin
                        n_state = mbra_pkg::ST_DIV;
                    end else if (i_stat.ping_req) begin
                        n_state = mbra_pkg::ST_DONE;
                    end
                end
            end
            mbra_pkg::ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (div_last) begin
                    n_state = mbra_pkg::ST_DONE;
                end
            end
            mbra_pkg::ST_DONE: begin
                if (i_out_ready) begin
                    n_state = mbra_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mbra_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.div_step = 1'b0;
        case (r_state)
            mbra_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            mbra_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            mbra_pkg::ST_DONE: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // the last divide step hands over to the result
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbra_pkg::ST_DIV && div_last) |=> (r_state == mbra_pkg::ST_DONE))
        else $error("divide did not finish into result state");

    // no new item while a result waits
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while result pending");

    // an item with no report leaves the block idle
    a_no_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && !i_stat.div_req && !i_stat.ping_req)
        |=> (r_state == mbra_pkg::ST_IDLE))
        else $error("silent item left the block busy");
`endif

endmodule

// ===== src/mbra_dp.sv =====
// datapath: latency capture, sorted batch, median sum and serial divider
module mbra_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbra_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  mbra_pkg::t_ctl_cmd  i_cmd,
    output mbra_pkg::t_dp_stat  o_stat,
    output mbra_pkg::t_out_item o_result
);

    localparam int unsigned N = mbra_pkg::MaxBatch;
    localparam int unsigned IdxW_L = mbra_pkg::IdxW;

    // configuration
    logic [4:0]  r_batch_size;
    logic [31:0] r_interval;

    // control state
    logic [47:0] r_pending;
    logic        r_start_valid;
    logic [4:0]  r_fill;
    logic [63:0] r_sum;
    logic [31:0] r_count;
    logic [47:0] r_deadline;
    logic        r_has_reported;

    // sorted batch cells
    logic [31:0] r_sorted [N];
    logic [31:0] n_sorted [N];

    // divider and result
    logic [31:0] r_rem, r_lo, r_div, r_q, r_rcount;
    logic        r_from_ping;

    logic [4:0]  size_n, fill_eff, fill_inc;
    logic [IdxW_L-1:0] med_idx;
    logic [48:0] lat_diff;
    logic [31:0] lat;
    logic        le [N];
    logic [31:0] median;
    logic        batch_full;
    logic [48:0] rearm_sum;
    logic [47:0] rearm;
    logic        reached, is_sync, report, div_req, ping_req;
    logic [32:0] div_t, div_sub;

    // latency, saturated at 32 bits, zero when time runs backwards
    assign lat_diff = {1'b0, i_item.now_us} - {1'b0, r_pending};
    always_comb begin
        if (lat_diff[48]) begin
            lat = '0;
        end else if (lat_diff[47:32] != '0) begin
            lat = '1;
        end else begin
            lat = lat_diff[31:0];
        end
    end

    // batch fill, dropping a partial batch that outgrew the size
    assign size_n   = mbra_pkg::eff_size(r_batch_size);
    assign fill_eff = (r_fill >= size_n) ? 5'd0 : r_fill;
    assign fill_inc = fill_eff + 5'd1;
    assign batch_full = (fill_inc == size_n);
    assign med_idx  = IdxW_L'(size_n >> 1);

    // insertion into the sorted row of cells
    always_comb begin
        for (int i = 0; i < N; i++) begin
            le[i] = (r_sorted[i] <= lat);
        end
        for (int i = 0; i < N; i++) begin
            if ((5'(i) > fill_eff) || ((5'(i) < fill_eff) && le[i])) begin
                n_sorted[i] = r_sorted[i];
            end else if (i == 0) begin
                n_sorted[i] = lat;
            end else if (le[(i == 0) ? 0 : i - 1]) begin
                n_sorted[i] = lat;
            end else begin
                n_sorted[i] = r_sorted[(i == 0) ? 0 : i - 1];
            end
        end
    end
    assign median = n_sorted[med_idx];

    // deadline test and rearm time
    assign rearm_sum = {1'b0, i_item.now_us} + {17'd0, r_interval};
    assign rearm     = rearm_sum[48] ? '1 : rearm_sum[47:0];
    assign reached   = (r_deadline < i_item.now_us);
    assign is_sync   = i_item.cmd[1];
    assign report    = is_sync && (reached || (i_item.cmd == mbra_pkg::CMD_FINAL));
    assign div_req   = report && (r_count != '0);
    assign ping_req  = report && (r_count == '0) && (reached || !r_has_reported);

    assign o_stat.div_req  = div_req;
    assign o_stat.ping_req = ping_req;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_size <= mbra_pkg::BATCH_SIZE_RST;
            r_interval   <= mbra_pkg::SYNC_INTERVAL_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == mbra_pkg::REG_BATCH_SIZE) begin
                r_batch_size <= i_cfg_data[4:0];
            end else begin
                r_interval <= i_cfg_data;
            end
        end
    end

    // statistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending      <= '0;
            r_start_valid  <= 1'b0;
            r_fill         <= '0;
            r_sum          <= '0;
            r_count        <= '0;
            r_deadline     <= {16'd0, mbra_pkg::SYNC_INTERVAL_RST};
            r_has_reported <= 1'b0;
        end else if (i_cmd.accept) begin
            case (i_item.cmd)
                mbra_pkg::CMD_START: begin
                    r_pending     <= i_item.now_us;
                    r_start_valid <= 1'b1;
                end
                mbra_pkg::CMD_FINISH: begin
                    if (r_start_valid) begin
                        r_start_valid <= 1'b0;
                        if (batch_full) begin
                            r_fill <= '0;
                            if (r_count != '1) begin
                                r_sum   <= r_sum + {32'd0, median};
                                r_count <= r_count + 32'd1;
                            end
                        end else begin
                            r_fill <= fill_inc;
                        end
                    end
                end
                default: begin
                    if (reached || div_req || ping_req) begin
                        r_deadline <= rearm;
                    end
                    if (div_req || ping_req) begin
                        r_has_reported <= 1'b1;
                        r_fill         <= '0;
                        r_sum          <= '0;
                        r_count        <= '0;
                    end
                end
            endcase
        end
    end

    // sorted cells take the new latency on a finish
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_item.cmd == mbra_pkg::CMD_FINISH) && r_start_valid) begin
            for (int i = 0; i < N; i++) begin
                r_sorted[i] <= n_sorted[i];
            end
        end
    end

    // restoring divide step: quotient fits in 32 bits since sum < count * 2^32
    assign div_t   = {r_rem, r_lo[31]};
    assign div_sub = div_t - {1'b0, r_div};

    // divider and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && div_req) begin
            r_rem       <= r_sum[63:32];
            r_lo        <= r_sum[31:0];
            r_div       <= r_count;
            r_rcount    <= r_count;
            r_from_ping <= 1'b0;
        end else if (i_cmd.accept && ping_req) begin
            r_q         <= i_item.ping_us;
            r_rcount    <= 32'd1;
            r_from_ping <= 1'b1;
        end else if (i_cmd.div_step) begin
            r_lo <= {r_lo[30:0], 1'b0};
            if (!div_sub[32]) begin
                r_rem <= div_sub[31:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= div_t[31:0];
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end

    assign o_result.avg_latency_us = r_q;
    assign o_result.report_count   = r_rcount;
    assign o_result.from_ping      = r_from_ping;

endmodule
